/* rtl/keypad_press_long_press_tracker_top_defines.svh */
// Assertion macros used by the checker file.
`ifndef KEYPAD_PRESS_LONG_PRESS_TRACKER_TOP_DEFINES_SVH
`define KEYPAD_PRESS_LONG_PRESS_TRACKER_TOP_DEFINES_SVH

// same-cycle implication
`define KPLP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KPLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/kplp_pkg.sv */
package kplp_pkg;

	localparam int KEYS   = 8;
	localparam int KEY_AW = (KEYS > 1) ? $clog2(KEYS) : 1;

	typedef enum logic [1:0] {
		PH_RELEASED = 2'd0,
		PH_PREPRESS = 2'd1,
		PH_PRESSED  = 2'd2,
		PH_LONG     = 2'd3
	} phase_t;

	localparam logic [1:0] EV_PRESSED  = 2'd0;
	localparam logic [1:0] EV_RELEASED = 2'd1;
	localparam logic [1:0] EV_LONG     = 2'd2;

	typedef enum logic [1:0] {
		REG_ACTIVE_HIGH_MASK = 2'd0,
		REG_LONG_PRESS_MS    = 2'd1,
		REG_DEBOUNCE_MS      = 2'd2,
		REG_DEBOUNCE_ENABLE  = 2'd3
	} cfg_reg_t;

	localparam logic [15:0] LONG_PRESS_RESET = 16'd2000;
	localparam logic [7:0]  DEBOUNCE_RESET   = 8'd10;

	typedef struct packed {
		logic [2:0]  key_index;
		logic        pin_level;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [2:0] event_key;
		logic [1:0] event_kind;
	} out_item_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] start_ms;
	} key_state_t;

	typedef struct packed {
		logic [7:0]  active_high_mask;
		logic [15:0] long_press_ms;
		logic [7:0]  debounce_ms;
		logic        debounce_enable;
	} cfg_t;

endpackage

/* rtl/kplp_state_mem.sv */
module kplp_state_mem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [kplp_pkg::KEY_AW-1:0] rd_addr,
	input  logic                      wr_en,
	input  logic [kplp_pkg::KEY_AW-1:0] wr_addr,
	input  kplp_pkg::key_state_t      wr_data,
	output kplp_pkg::key_state_t      rd_data
);
	import kplp_pkg::*;

	key_state_t mem [KEYS];
	logic [KEYS-1:0] valid_q;
	key_state_t rdata_s1;
	key_state_t byp_data_s1;
	logic vld_s1;
	logic byp_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1    <= mem[rd_addr];
			byp_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
			byp_s1  <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= valid_q[rd_addr];
				byp_s1 <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	// write-to-read forwarding, unwritten entries read as reset state
	always_comb begin
		if (byp_s1) begin
			rd_data = byp_data_s1;
		end else if (vld_s1) begin
			rd_data = rdata_s1;
		end else begin
			rd_data = '0;
		end
	end

endmodule

/* rtl/kplp_step.sv */
module kplp_step (
	input  kplp_pkg::in_item_t   item,
	input  kplp_pkg::key_state_t cur,
	input  kplp_pkg::cfg_t       cfg,
	output kplp_pkg::key_state_t nxt,
	output logic                 emit,
	output logic [1:0]           kind
);
	import kplp_pkg::*;

	logic        down;
	logic [31:0] elapsed;
	logic        deb_done;
	logic        long_done;

	assign down      = (item.pin_level == cfg.active_high_mask[item.key_index]);
	assign elapsed   = item.now_ms - cur.start_ms;
	assign deb_done  = elapsed > {24'd0, cfg.debounce_ms};
	assign long_done = elapsed > {16'd0, cfg.long_press_ms};

	always_comb begin
		nxt  = cur;
		emit = 1'b0;
		kind = EV_PRESSED;
		unique case (cur.phase)
			PH_RELEASED: begin
				if (down) begin
					nxt.start_ms = item.now_ms;
					if (cfg.debounce_enable) begin
						nxt.phase = PH_PREPRESS;
					end else begin
						nxt.phase = PH_PRESSED;
						emit      = 1'b1;
					end
				end
			end
			PH_PREPRESS: begin
				if (!down) begin
					nxt.phase = PH_RELEASED;
				end else if (deb_done) begin
					nxt.phase    = PH_PRESSED;
					nxt.start_ms = item.now_ms;
					emit         = 1'b1;
				end
			end
			PH_PRESSED, PH_LONG: begin
				if (!down) begin
					nxt.phase    = PH_RELEASED;
					nxt.start_ms = '0;
					emit         = 1'b1;
					kind         = EV_RELEASED;
				end else if (cur.phase == PH_PRESSED && long_done) begin
					nxt.phase    = PH_LONG;
					nxt.start_ms = item.now_ms;
					emit         = 1'b1;
					kind         = EV_LONG;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

/* rtl/keypad_press_long_press_tracker_top.sv */
// Keypad press / long-press tracker.
// Input channel (in_valid/in_stall/in_data): one sampled pin level of one key
// plus the current millisecond tick. Output channel (out_valid/out_stall/
// out_data): zero or one event per request: pressed, released or long pressed.
// Config port (cfg_we/cfg_index/cfg_data): polarity mask, long-press time,
// debounce time and debounce enable; write only while idle.
// Per-key phase and start tick live in a synchronous state memory; stage 0
// issues the read, stage 1 updates the entry, writes it back and loads the
// output register. Back-to-back requests to the same key use forwarding.
// Throughput: one request per cycle while in_stall is low. An event passes
// the stage 1 register and then the output register before it reaches out_data.
// Reset clears all key state to released (per-entry valid bits, no sweep),
// and loads the register defaults.
// A stalled event holds out_data; stage 1 keeps accepting requests that cause
// no event, and in_stall rises only when an event is blocked behind it.
module keypad_press_long_press_tracker_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  kplp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output kplp_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import kplp_pkg::*;

	cfg_t       cfg_q;
	in_item_t   item_s1;
	logic       valid_s1;
	key_state_t cur_state;
	key_state_t nxt_state;
	logic       emit;
	logic [1:0] kind;
	logic       in_range_s1;
	logic       out_free;
	logic       go_s1;
	logic       accept;
	logic       out_valid_q;
	out_item_t  out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_high_mask <= '0;
			cfg_q.long_press_ms    <= LONG_PRESS_RESET;
			cfg_q.debounce_ms      <= DEBOUNCE_RESET;
			cfg_q.debounce_enable  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ACTIVE_HIGH_MASK: cfg_q.active_high_mask <= cfg_data[7:0];
				REG_LONG_PRESS_MS:    cfg_q.long_press_ms    <= cfg_data;
				REG_DEBOUNCE_MS:      cfg_q.debounce_ms      <= cfg_data[7:0];
				REG_DEBOUNCE_ENABLE:  cfg_q.debounce_enable  <= cfg_data[0];
				default:              cfg_q                  <= cfg_q;
			endcase
		end
	end

	assign in_range_s1 = ({29'd0, item_s1.key_index} < 32'(KEYS));
	assign out_free    = !out_valid_q || !out_stall;
	assign go_s1       = valid_s1 && (out_free || !(emit && in_range_s1));
	assign in_stall    = valid_s1 && !go_s1;
	assign accept      = in_valid && !in_stall;

	kplp_state_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (in_data.key_index[KEY_AW-1:0]),
		.wr_en   (go_s1 && in_range_s1),
		.wr_addr (item_s1.key_index[KEY_AW-1:0]),
		.wr_data (nxt_state),
		.rd_data (cur_state)
	);

	kplp_step u_step (
		.item (item_s1),
		.cur  (cur_state),
		.cfg  (cfg_q),
		.nxt  (nxt_state),
		.emit (emit),
		.kind (kind)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
		if (go_s1 && emit && in_range_s1) begin
			out_data_q.event_key  <= item_s1.key_index;
			out_data_q.event_kind <= kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (go_s1) begin
				valid_s1 <= 1'b0;
			end
			if (go_s1 && emit && in_range_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* rtl/kplp_checker.sv */
`include "keypad_press_long_press_tracker_top_defines.svh"

module kplp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input kplp_pkg::out_item_t out_data
);
	import kplp_pkg::*;

	`KPLP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_data), "event dropped or changed while stalled")

	`KPLP_ASSERT_NOW(a_kind_legal, clk, arst_n, out_valid,
		out_data.event_kind <= EV_LONG, "illegal event kind")

	`KPLP_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall,
		out_valid && out_stall, "request stalled without a blocked event")

	`KPLP_ASSERT_NEXT(a_no_phantom, clk, arst_n,
		!out_valid && !$past(in_valid && !in_stall),
		!out_valid, "event without a request")

endmodule

bind keypad_press_long_press_tracker_top kplp_checker u_kplp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

/* dv/testbench.sv */
module testbench;
	import kplp_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 4;
	localparam int END_CYCLES    = 10;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	in_item_t    in_data   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	keypad_press_long_press_tracker_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// per-key tracking state and register shadow
	phase_t      key_mode  [KEYS];
	logic [31:0] key_since [KEYS];
	logic [7:0]  pol_mask;
	logic [15:0] hold_limit;
	logic [7:0]  bounce_limit;
	logic        bounce_on;

	out_item_t   expected_events [$];

	int          send_idle_pct   = 0;
	int          stall_pct       = 0;
	int          stall_hold_left = 0;
	int          mismatches      = 0;
	int          samples_sent    = 0;
	int          events_seen     = 0;
	int          cfg_writes      = 0;
	int          cycle_count     = 0;
	int          kind_seen [3]   = '{0, 0, 0};
	logic [31:0] tick            = '0;
	logic        last_level [KEYS];

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d events outstanding", cycle_count,
				expected_events.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic bit track_sample(input in_item_t s, output out_item_t ev);
		logic [2:0]  k;
		logic        down;
		logic [31:0] elapsed;
		logic [1:0]  kind;
		bit          fire;
		k       = s.key_index;
		down    = (s.pin_level == pol_mask[k]);
		elapsed = s.now_ms - key_since[k];
		kind    = EV_PRESSED;
		fire    = 1'b0;
		case (key_mode[k])
			PH_RELEASED: begin
				if (down) begin
					key_since[k] = s.now_ms;
					if (bounce_on) begin
						key_mode[k] = PH_PREPRESS;
					end else begin
						key_mode[k] = PH_PRESSED;
						fire = 1'b1;
					end
				end
			end
			PH_PREPRESS: begin
				if (!down) begin
					key_mode[k] = PH_RELEASED;
				end else if (elapsed > {24'd0, bounce_limit}) begin
					key_mode[k]  = PH_PRESSED;
					key_since[k] = s.now_ms;
					fire = 1'b1;
				end
			end
			default: begin
				if (!down) begin
					key_mode[k]  = PH_RELEASED;
					key_since[k] = '0;
					kind = EV_RELEASED;
					fire = 1'b1;
				end else if (key_mode[k] == PH_PRESSED && elapsed > {16'd0, hold_limit}) begin
					key_mode[k]  = PH_LONG;
					key_since[k] = s.now_ms;
					kind = EV_LONG;
					fire = 1'b1;
				end
			end
		endcase
		ev.event_key  = k;
		ev.event_kind = kind;
		return fire;
	endfunction

	function automatic in_item_t make_sample(input logic [2:0] k, input logic lvl,
			input logic [31:0] t);
		in_item_t s;
		s.key_index = k;
		s.pin_level = lvl;
		s.now_ms    = t;
		return s;
	endfunction

	// mostly held levels on a running tick; noisy samples jump anywhere
	function automatic in_item_t next_sample(input bit noisy);
		in_item_t s;
		int       pick;
		pick = $urandom_range(99);
		if (pick < 40)
			tick += $urandom_range(3);
		else if (pick < 70)
			tick += $urandom_range(40);
		else if (pick < 85)
			tick += $urandom_range(400);
		else if (pick < 95)
			tick += $urandom_range(3000, 1500);
		else
			tick += $urandom_range(80000);
		s.key_index = 3'($urandom_range(7));
		if (noisy) begin
			s.pin_level = 1'($urandom_range(1));
			s.now_ms    = $urandom();
		end else begin
			if ($urandom_range(99) < 30)
				last_level[s.key_index] = ~last_level[s.key_index];
			s.pin_level = last_level[s.key_index];
			s.now_ms    = tick;
		end
		return s;
	endfunction

	// result checker and receiver stall
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			events_seen++;
			if (expected_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected event: expected none, got key %0d kind %0d",
						out_data.event_key, out_data.event_kind);
			end else begin
				want = expected_events.pop_front();
				if (want.event_key !== out_data.event_key ||
						want.event_kind !== out_data.event_kind) begin
					mismatches++;
					if (mismatches <= 10)
						$display("event mismatch: expected key %0d kind %0d, got key %0d kind %0d",
							want.event_key, want.event_kind,
							out_data.event_key, out_data.event_kind);
				end else begin
					kind_seen[want.event_kind]++;
				end
			end
		end
		if (stall_hold_left > 0) begin
			out_stall <= 1'b1;
			stall_hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_sample(input in_item_t s);
		out_item_t ev;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		samples_sent++;
		if (track_sample(s, ev))
			expected_events.push_back(ev);
	endtask

	task automatic wait_events_done();
		in_valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_writes++;
		case (idx)
			REG_ACTIVE_HIGH_MASK: pol_mask     = val[7:0];
			REG_LONG_PRESS_MS:    hold_limit   = val;
			REG_DEBOUNCE_MS:      bounce_limit = val[7:0];
			REG_DEBOUNCE_ENABLE:  bounce_on    = val[0];
		endcase
	endtask

	task automatic reconfigure(input logic [15:0] mask_v, long_v, deb_v, en_v);
		wait_events_done();
		write_reg(REG_ACTIVE_HIGH_MASK, mask_v);
		write_reg(REG_LONG_PRESS_MS, long_v);
		write_reg(REG_DEBOUNCE_MS, deb_v);
		write_reg(REG_DEBOUNCE_ENABLE, en_v);
		cfg_we <= 1'b0;
	endtask

	// reset defaults: low level pressed, 2000 ms hold, no debounce
	task automatic test_reset_defaults();
		send_sample(make_sample(3'd0, 1'b0, 32'd100));
		send_sample(make_sample(3'd0, 1'b0, 32'd2100));
		send_sample(make_sample(3'd0, 1'b0, 32'd2101));
		send_sample(make_sample(3'd0, 1'b0, 32'hFFFF_FFFF));
		send_sample(make_sample(3'd0, 1'b1, 32'd5));
		send_sample(make_sample(3'd0, 1'b1, 32'd6));
		// hold across the tick wrap
		send_sample(make_sample(3'd1, 1'b0, 32'hFFFF_FFF0));
		send_sample(make_sample(3'd1, 1'b0, 32'h0000_07C1));
		send_sample(make_sample(3'd1, 1'b1, 32'h0000_0800));
	endtask

	task automatic test_debounce_path();
		reconfigure(16'h00FF, 16'd0, 16'd0, 16'd1);
		send_sample(make_sample(3'd7, 1'b1, 32'd50));
		send_sample(make_sample(3'd7, 1'b1, 32'd50));
		send_sample(make_sample(3'd7, 1'b1, 32'd51));
		send_sample(make_sample(3'd7, 1'b1, 32'd51));
		send_sample(make_sample(3'd7, 1'b1, 32'd52));
		send_sample(make_sample(3'd7, 1'b0, 32'd53));
		// pre-press abandoned
		send_sample(make_sample(3'd3, 1'b1, 32'd60));
		send_sample(make_sample(3'd3, 1'b0, 32'd61));
		// debounce turned off while key 4 sits in pre-press
		send_sample(make_sample(3'd4, 1'b1, 32'd70));
		reconfigure(16'h00FF, 16'd0, 16'd255, 16'd0);
		send_sample(make_sample(3'd4, 1'b1, 32'd325));
		send_sample(make_sample(3'd4, 1'b1, 32'd326));
	endtask

	task automatic test_long_hold_extremes();
		reconfigure(16'h0000, 16'hFFFF, 16'd255, 16'd0);
		send_sample(make_sample(3'd4, 1'b0, 32'd326 + 32'd65535));
		send_sample(make_sample(3'd4, 1'b0, 32'd326 + 32'd65536));
		send_sample(make_sample(3'd4, 1'b1, 32'd326 + 32'd65537));
		send_sample(make_sample(3'd2, 1'b0, 32'd0));
		send_sample(make_sample(3'd2, 1'b1, 32'd0));
	endtask

	task automatic run_phase(input int n, idle, stall,
			input logic [15:0] mask_v, long_v, deb_v, en_v);
		reconfigure(mask_v, long_v, deb_v, en_v);
		send_idle_pct = idle;
		stall_pct     = stall;
		tick = $urandom_range(1) ? $urandom() : (32'hFFFF_FFFF - $urandom_range(5000));
		for (int i = 0; i < n; i++) begin
			send_sample(next_sample($urandom_range(99) < 15));
			if (i == n / 2)
				wait_events_done();
		end
	endtask

	task automatic test_random_traffic();
		run_phase(150, 0, 0, 16'd0, 16'd2000, 16'd10, 16'd0);
		run_phase(150, 0, 0, 16'hFFFF, 16'd0, 16'd0, 16'd1);
		run_phase(150, 88, 0, 16'($urandom()), 16'hFFFF, 16'd255, 16'd1);
		run_phase(150, 88, 0, 16'($urandom()), 16'($urandom_range(300)),
			16'($urandom()), 16'd0);
		run_phase(150, 0, 88, 16'h00A5, 16'd100, 16'd255, 16'd0);
		run_phase(150, 0, 88, 16'($urandom()), 16'($urandom_range(2500)),
			16'($urandom_range(40)), 16'd1);
		run_phase(150, 20, 20, 16'($urandom()), 16'($urandom()), 16'($urandom()),
			16'($urandom()));
		run_phase(150, 20, 20, 16'h0000, 16'd50, 16'd3, 16'd1);
	endtask

	// receiver held off while every request toggles its key
	task automatic test_output_backpressure();
		logic [2:0] k;
		reconfigure(16'h0000, 16'hFFFF, 16'd10, 16'd0);
		send_idle_pct   = 0;
		stall_pct       = 0;
		stall_hold_left = 300;
		for (int i = 0; i < 64; i++) begin
			k = 3'(i % KEYS);
			last_level[k] = ~last_level[k];
			tick += 1;
			send_sample(make_sample(k, last_level[k], tick));
		end
		wait_events_done();
	endtask

	initial begin
		for (int k = 0; k < KEYS; k++) begin
			key_mode[k]   = PH_RELEASED;
			key_since[k]  = '0;
			last_level[k] = 1'b1;
		end
		pol_mask     = '0;
		hold_limit   = LONG_PRESS_RESET;
		bounce_limit = DEBOUNCE_RESET;
		bounce_on    = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_debounce_path();
		test_long_hold_extremes();
		test_random_traffic();
		test_output_backpressure();

		wait_events_done();
		repeat (END_CYCLES) @(posedge clk);
		$display("Sent %0d key samples: directed cases, eight register settings,",
			samples_sent);
		$display("mixed idling and a hold-off; %0d events (%0d/%0d/%0d), %0d cfg writes.",
			events_seen, kind_seen[0], kind_seen[1], kind_seen[2], cfg_writes);
		if (mismatches == 0 && expected_events.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
